/* rtl/low_level_alarm_beeper_defines.svh */
// ----------------------------------------------------------------------------
// Low-level alarm beeper assertion macros
// Macros for the concurrent checks of the beeper sequencer.
// ----------------------------------------------------------------------------
`ifndef LOW_LEVEL_ALARM_BEEPER_DEFINES_SVH
`define LOW_LEVEL_ALARM_BEEPER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define LLAB_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define LLAB_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/llab_pkg.sv */
// ----------------------------------------------------------------------------
// Low-level alarm beeper package
// Widths, register codes, reset values, tone constants and shared structs.
// ----------------------------------------------------------------------------
package llab_pkg;

  localparam int MAX_CHANNELS     = 4;
  localparam int TIME_W           = 32;
  localparam int READ_W           = 8;
  localparam int COUNT_W          = 3;
  localparam int BEEPS_W          = 8;
  localparam int DUR_W            = 16;
  localparam int CFG_IDX_W        = 3;
  localparam int CFG_DATA_W       = 32;

  localparam int VOLT_CHANNELS    = 4;
  localparam int SIGNAL_CHANNELS  = 4;

  localparam logic [READ_W-1:0] DISABLED_LIMIT = 8'hFF;

  localparam logic [DUR_W-1:0] VOLT_TONE_FREQ   = 16'd2000;
  localparam logic [DUR_W-1:0] SIGNAL_TONE_FREQ = 16'd1000;
  localparam logic [DUR_W-1:0] VOLT_TONE_LEN    = 16'd200;
  localparam logic [DUR_W-1:0] SIGNAL_TONE_LEN  = 16'd200;

  localparam logic [31:0]        RST_LIMITS       = 32'hFFFF_FFFF;
  localparam logic [BEEPS_W-1:0] RST_VOLT_BEEPS   = 8'd3;
  localparam logic [BEEPS_W-1:0] RST_SIGNAL_TONES = 8'd2;
  localparam logic [DUR_W-1:0]   RST_GAP          = 16'd300;
  localparam logic [DUR_W-1:0]   RST_PAUSE        = 16'd5000;

  localparam logic KIND_VOLT   = 1'b0;
  localparam logic KIND_SIGNAL = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VOLT_LIMITS   = 3'd0,
    REG_SIGNAL_LIMITS = 3'd1,
    REG_VOLT_BEEPS    = 3'd2,
    REG_SIGNAL_TONES  = 3'd3,
    REG_VOLT_GAP      = 3'd4,
    REG_VOLT_PAUSE    = 3'd5,
    REG_SIGNAL_GAP    = 3'd6,
    REG_SIGNAL_PAUSE  = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [31:0]        volt_limits;
    logic [31:0]        signal_limits;
    logic [BEEPS_W-1:0] volt_beeps;
    logic [BEEPS_W-1:0] signal_tones;
    logic [DUR_W-1:0]   volt_gap;
    logic [DUR_W-1:0]   volt_pause;
    logic [DUR_W-1:0]   signal_gap;
    logic [DUR_W-1:0]   signal_pause;
  } cfg_t;

  typedef struct packed {
    logic               tone_start;
    logic               tone_kind;
    logic [DUR_W-1:0]   tone_freq;
    logic [DUR_W-1:0]   tone_length;
    logic               volt_alarm_out;
    logic               signal_alarm_out;
    logic [BEEPS_W-1:0] beep_index;
  } result_t;

endpackage

/* rtl/llab_sample_if.sv */
// ----------------------------------------------------------------------------
// Low-level alarm beeper sample channel
// Valid/ready channel carrying one time stamp and the channel readings.
// ----------------------------------------------------------------------------
interface llab_sample_if;
  logic                                 valid;
  logic                                 ready;
  logic [llab_pkg::TIME_W-1:0]          now;
  logic [llab_pkg::READ_W-1:0]          volt_0;
  logic [llab_pkg::READ_W-1:0]          volt_1;
  logic [llab_pkg::READ_W-1:0]          volt_2;
  logic [llab_pkg::READ_W-1:0]          volt_3;
  logic [llab_pkg::READ_W-1:0]          signal_0;
  logic [llab_pkg::READ_W-1:0]          signal_1;
  logic [llab_pkg::READ_W-1:0]          signal_2;
  logic [llab_pkg::READ_W-1:0]          signal_3;
  logic [llab_pkg::COUNT_W-1:0]         volt_count;
  logic [llab_pkg::COUNT_W-1:0]         signal_count;

  modport source (
    output valid, now, volt_0, volt_1, volt_2, volt_3,
           signal_0, signal_1, signal_2, signal_3, volt_count, signal_count,
    input  ready
  );
  modport sink (
    input  valid, now, volt_0, volt_1, volt_2, volt_3,
           signal_0, signal_1, signal_2, signal_3, volt_count, signal_count,
    output ready
  );
endinterface

/* rtl/llab_result_if.sv */
// ----------------------------------------------------------------------------
// Low-level alarm beeper result channel
// Valid/ready channel carrying the tone command and alarm status.
// ----------------------------------------------------------------------------
interface llab_result_if;
  logic                          valid;
  logic                          ready;
  logic                          tone_start;
  logic                          tone_kind;
  logic [llab_pkg::DUR_W-1:0]    tone_freq;
  logic [llab_pkg::DUR_W-1:0]    tone_length;
  logic                          volt_alarm_out;
  logic                          signal_alarm_out;
  logic [llab_pkg::BEEPS_W-1:0]  beep_index;

  modport source (
    output valid, tone_start, tone_kind, tone_freq, tone_length,
           volt_alarm_out, signal_alarm_out, beep_index,
    input  ready
  );
  modport sink (
    input  valid, tone_start, tone_kind, tone_freq, tone_length,
           volt_alarm_out, signal_alarm_out, beep_index,
    output ready
  );
endinterface

/* rtl/llab_cfg_if.sv */
// ----------------------------------------------------------------------------
// Low-level alarm beeper configuration channel
// Valid/ready register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface llab_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [llab_pkg::CFG_IDX_W-1:0]    index;
  logic [llab_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* rtl/low_level_alarm_beeper.sv */
// ----------------------------------------------------------------------------
// Low-level alarm beeper
// Top level: configuration registers, comparison lanes, sequencer, output
// register.
// ----------------------------------------------------------------------------
// One sample transaction is taken every clock cycle while the output register
// is empty or being drained. Each sample passes through the parallel voltage
// and signal comparison lanes and the shared tone sequencer combinationally
// and lands in the output register, so a result appears in the cycle after
// its sample is taken; throughput is set only by the output register, which
// refills in the cycle it is drained. Configuration writes are always
// accepted and must be issued while no sample is in flight.
module low_level_alarm_beeper #(
  parameter int VOLT_CHANNELS   = llab_pkg::VOLT_CHANNELS,
  parameter int SIGNAL_CHANNELS = llab_pkg::SIGNAL_CHANNELS
) (
  input  logic           clk,
  input  logic           rst,
  llab_sample_if.sink    samples,
  llab_result_if.source  results,
  llab_cfg_if.sink       cfg
);

  llab_pkg::cfg_t                          regs;
  llab_pkg::result_t                       res;
  llab_pkg::result_t                       res_q;
  logic                                    out_valid;
  logic                                    step;
  logic [llab_pkg::MAX_CHANNELS-1:0]       volt_hits;
  logic [llab_pkg::MAX_CHANNELS-1:0]       signal_hits;
  logic [llab_pkg::READ_W-1:0]             volt_rd   [llab_pkg::MAX_CHANNELS];
  logic [llab_pkg::READ_W-1:0]             signal_rd [llab_pkg::MAX_CHANNELS];

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.volt_limits   <= llab_pkg::RST_LIMITS;
      regs.signal_limits <= llab_pkg::RST_LIMITS;
      regs.volt_beeps    <= llab_pkg::RST_VOLT_BEEPS;
      regs.signal_tones  <= llab_pkg::RST_SIGNAL_TONES;
      regs.volt_gap      <= llab_pkg::RST_GAP;
      regs.volt_pause    <= llab_pkg::RST_PAUSE;
      regs.signal_gap    <= llab_pkg::RST_GAP;
      regs.signal_pause  <= llab_pkg::RST_PAUSE;
    end else if (cfg.valid) begin
      unique case (llab_pkg::cfg_reg_t'(cfg.index))
        llab_pkg::REG_VOLT_LIMITS:   regs.volt_limits   <= cfg.data;
        llab_pkg::REG_SIGNAL_LIMITS: regs.signal_limits <= cfg.data;
        llab_pkg::REG_VOLT_BEEPS:    regs.volt_beeps    <= cfg.data[llab_pkg::BEEPS_W-1:0];
        llab_pkg::REG_SIGNAL_TONES:  regs.signal_tones  <= cfg.data[llab_pkg::BEEPS_W-1:0];
        llab_pkg::REG_VOLT_GAP:      regs.volt_gap      <= cfg.data[llab_pkg::DUR_W-1:0];
        llab_pkg::REG_VOLT_PAUSE:    regs.volt_pause    <= cfg.data[llab_pkg::DUR_W-1:0];
        llab_pkg::REG_SIGNAL_GAP:    regs.signal_gap    <= cfg.data[llab_pkg::DUR_W-1:0];
        llab_pkg::REG_SIGNAL_PAUSE:  regs.signal_pause  <= cfg.data[llab_pkg::DUR_W-1:0];
        default: ;
      endcase
    end
  end

  assign samples.ready = !out_valid || results.ready;
  assign step          = samples.valid && samples.ready;

  assign volt_rd[0]   = samples.volt_0;
  assign volt_rd[1]   = samples.volt_1;
  assign volt_rd[2]   = samples.volt_2;
  assign volt_rd[3]   = samples.volt_3;
  assign signal_rd[0] = samples.signal_0;
  assign signal_rd[1] = samples.signal_1;
  assign signal_rd[2] = samples.signal_2;
  assign signal_rd[3] = samples.signal_3;

  for (genvar i = 0; i < llab_pkg::MAX_CHANNELS; i++) begin : g_lanes
    if (i < VOLT_CHANNELS) begin : g_volt
      llab_lane u_volt (
        .active  (samples.volt_count > llab_pkg::COUNT_W'(i)),
        .reading (volt_rd[i]),
        .limit   (regs.volt_limits[llab_pkg::READ_W*i +: llab_pkg::READ_W]),
        .hit     (volt_hits[i])
      );
    end else begin : g_volt_off
      assign volt_hits[i] = 1'b0;
    end
    if (i < SIGNAL_CHANNELS) begin : g_signal
      llab_lane u_signal (
        .active  (samples.signal_count > llab_pkg::COUNT_W'(i)),
        .reading (signal_rd[i]),
        .limit   (regs.signal_limits[llab_pkg::READ_W*i +: llab_pkg::READ_W]),
        .hit     (signal_hits[i])
      );
    end else begin : g_signal_off
      assign signal_hits[i] = 1'b0;
    end
  end

  llab_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .now         (samples.now),
    .volt_hits   (volt_hits),
    .signal_hits (signal_hits),
    .cfg         (regs),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (samples.ready) begin
      out_valid <= step;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_q <= res;
    end
  end

  assign results.valid            = out_valid;
  assign results.tone_start       = res_q.tone_start;
  assign results.tone_kind        = res_q.tone_kind;
  assign results.tone_freq        = res_q.tone_freq;
  assign results.tone_length      = res_q.tone_length;
  assign results.volt_alarm_out   = res_q.volt_alarm_out;
  assign results.signal_alarm_out = res_q.signal_alarm_out;
  assign results.beep_index       = res_q.beep_index;

endmodule

/* rtl/llab_lane.sv */
// ----------------------------------------------------------------------------
// Low-level alarm beeper channel lane
// Compare one reading against its threshold byte; flag a hit when in use.
// ----------------------------------------------------------------------------
module llab_lane (
  input  logic                          active,
  input  logic [llab_pkg::READ_W-1:0]   reading,
  input  logic [llab_pkg::READ_W-1:0]   limit,
  output logic                          hit
);

  assign hit = active && (limit != llab_pkg::DISABLED_LIMIT) && (reading < limit);

endmodule

/* rtl/llab_seq.sv */
// ----------------------------------------------------------------------------
// Low-level alarm beeper sequencer
// Merge lane hits, latch alarms and run the shared tone sequencer.
// ----------------------------------------------------------------------------
`include "low_level_alarm_beeper_defines.svh"

module llab_seq (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  step,
  input  logic [llab_pkg::TIME_W-1:0]           now,
  input  logic [llab_pkg::MAX_CHANNELS-1:0]     volt_hits,
  input  logic [llab_pkg::MAX_CHANNELS-1:0]     signal_hits,
  input  llab_pkg::cfg_t                        cfg,
  output llab_pkg::result_t                     res
);

  logic                            volt_alarm;
  logic                            signal_alarm;
  logic [llab_pkg::TIME_W-1:0]     last_tone_time;
  logic [llab_pkg::BEEPS_W-1:0]    beep_counter;

  logic                            volt_alarm_next;
  logic                            signal_alarm_next;
  logic [llab_pkg::TIME_W-1:0]     last_tone_time_next;
  logic [llab_pkg::BEEPS_W-1:0]    beep_counter_next;

  logic                            volt_hit;
  logic                            signal_hit;
  logic                            run;
  logic                            started;
  logic [llab_pkg::BEEPS_W-1:0]    beeps;
  logic [llab_pkg::DUR_W-1:0]      gap;
  logic [llab_pkg::DUR_W-1:0]      pause;
  logic [llab_pkg::TIME_W-1:0]     since;

  assign volt_hit   = |volt_hits;
  assign signal_hit = |signal_hits;

  always_comb begin
    volt_alarm_next     = volt_alarm | volt_hit;
    signal_alarm_next   = signal_alarm | signal_hit;
    last_tone_time_next = last_tone_time;
    beep_counter_next   = beep_counter;
    started             = 1'b0;
    run                 = volt_alarm_next | signal_alarm_next;
    beeps = signal_alarm_next ? cfg.signal_tones : cfg.volt_beeps;
    gap   = signal_alarm_next ? cfg.signal_gap   : cfg.volt_gap;
    pause = signal_alarm_next ? cfg.signal_pause : cfg.volt_pause;
    since = now - last_tone_time;

    if (run) begin
      if (beep_counter == '0) begin
        beep_counter_next   = llab_pkg::BEEPS_W'(1);
        last_tone_time_next = now;
        started             = 1'b1;
      end else if (beep_counter < beeps) begin
        if (since > llab_pkg::TIME_W'(gap)) begin
          beep_counter_next   = beep_counter + llab_pkg::BEEPS_W'(1);
          last_tone_time_next = now;
          started             = 1'b1;
        end
      end else if (since > llab_pkg::TIME_W'(pause)) begin
        beep_counter_next   = '0;
        last_tone_time_next = '0;
      end
    end

    // drop latched alarms once quiet and idle
    if (!volt_hit && !signal_hit && (beep_counter_next == '0)) begin
      volt_alarm_next     = 1'b0;
      signal_alarm_next   = 1'b0;
      last_tone_time_next = '0;
    end

    res.tone_start       = started;
    res.tone_kind        = started ? signal_alarm_next : llab_pkg::KIND_VOLT;
    res.tone_freq        = '0;
    res.tone_length      = '0;
    if (started) begin
      res.tone_freq   = signal_alarm_next ? llab_pkg::SIGNAL_TONE_FREQ
                                          : llab_pkg::VOLT_TONE_FREQ;
      res.tone_length = signal_alarm_next ? llab_pkg::SIGNAL_TONE_LEN
                                          : llab_pkg::VOLT_TONE_LEN;
    end
    res.volt_alarm_out   = volt_alarm_next;
    res.signal_alarm_out = signal_alarm_next;
    res.beep_index       = beep_counter_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      volt_alarm     <= 1'b0;
      signal_alarm   <= 1'b0;
      last_tone_time <= '0;
      beep_counter   <= '0;
    end else if (step) begin
      volt_alarm     <= volt_alarm_next;
      signal_alarm   <= signal_alarm_next;
      last_tone_time <= last_tone_time_next;
      beep_counter   <= beep_counter_next;
    end
  end

  `LLAB_ASSERT_NOW(a_idle_counter, !volt_alarm && !signal_alarm, beep_counter == '0, "beep counter running without alarm")
  `LLAB_ASSERT_NEXT(a_tone_marks, step && started, (last_tone_time == $past(now)) && (beep_counter != '0), "tone start did not record time and count")
  `LLAB_ASSERT_NEXT(a_hold_state, !step, $stable(beep_counter) && $stable(last_tone_time) && $stable(volt_alarm) && $stable(signal_alarm), "sequencer state moved without a transaction")

endmodule

/* tb/sv/llab_beep_monitor.sv */
// ----------------------------------------------------------------------------
// Low-level alarm beeper result monitor
// Watches the sample, result and register write channels of the beeper. It
// keeps its own copy of the registers, the latched alarms and the shared tone
// sequencer, works out the status that each accepted sample must produce,
// and compares every accepted result with the oldest outstanding one.
// ----------------------------------------------------------------------------
module llab_beep_monitor
  import llab_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  llab_sample_if samples,
  llab_result_if results,
  llab_cfg_if    cfg,
  output int     bad_results,
  output int     results_due
);
  timeunit 1ns;
  timeprecision 1ps;

  cfg_t               regs;
  logic               volt_alarm;
  logic               sig_alarm;
  logic [TIME_W-1:0]  last_tone;
  logic [BEEPS_W-1:0] beep_cnt;
  result_t            due[$];
  int                 bad_count;

  function automatic logic any_low(input logic [31:0] reads, input logic [COUNT_W-1:0] cnt,
                                   input logic [31:0] limits, input int chans);
    int   used;
    logic hit;
    used = (cnt > chans) ? chans : int'(cnt);
    hit  = 1'b0;
    for (int c = 0; c < used && c < MAX_CHANNELS; c++) begin
      if (limits[8*c +: 8] != DISABLED_LIMIT && reads[8*c +: 8] < limits[8*c +: 8]) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

  function automatic logic tone_due(input logic [TIME_W-1:0] t, input logic [BEEPS_W-1:0] beeps,
                                    input logic [DUR_W-1:0] gap, input logic [DUR_W-1:0] pause);
    logic [TIME_W-1:0] since;
    since = t - last_tone;
    if (beep_cnt == '0) begin
      beep_cnt  = 8'd1;
      last_tone = t;
      return 1'b1;
    end
    if (beep_cnt < beeps) begin
      if (since > {16'h0, gap}) begin
        beep_cnt  = beep_cnt + 8'd1;
        last_tone = t;
        return 1'b1;
      end
      return 1'b0;
    end
    if (since > {16'h0, pause}) begin
      beep_cnt  = '0;
      last_tone = '0;
    end
    return 1'b0;
  endfunction

  function automatic result_t beep_step(input logic [TIME_W-1:0] t, input logic [31:0] volts,
                                        input logic [31:0] sigs, input logic [COUNT_W-1:0] vc,
                                        input logic [COUNT_W-1:0] sc);
    result_t r;
    logic    sig_hit;
    logic    volt_hit;
    sig_hit  = any_low(sigs, sc, regs.signal_limits, SIGNAL_CHANNELS);
    volt_hit = any_low(volts, vc, regs.volt_limits, VOLT_CHANNELS);
    r = '0;
    if (sig_hit) sig_alarm = 1'b1;
    if (volt_hit) volt_alarm = 1'b1;
    if (sig_alarm) begin
      if (tone_due(t, regs.signal_tones, regs.signal_gap, regs.signal_pause)) begin
        r.tone_start  = 1'b1;
        r.tone_kind   = KIND_SIGNAL;
        r.tone_freq   = SIGNAL_TONE_FREQ;
        r.tone_length = SIGNAL_TONE_LEN;
      end
    end else if (volt_alarm) begin
      if (tone_due(t, regs.volt_beeps, regs.volt_gap, regs.volt_pause)) begin
        r.tone_start  = 1'b1;
        r.tone_kind   = KIND_VOLT;
        r.tone_freq   = VOLT_TONE_FREQ;
        r.tone_length = VOLT_TONE_LEN;
      end
    end
    if (!sig_hit && !volt_hit && beep_cnt == '0) begin
      volt_alarm = 1'b0;
      sig_alarm  = 1'b0;
      last_tone  = '0;
    end
    r.volt_alarm_out   = volt_alarm;
    r.signal_alarm_out = sig_alarm;
    r.beep_index       = beep_cnt;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    result_t seen;
    result_t want;
    if (rst) begin
      regs.volt_limits   = RST_LIMITS;
      regs.signal_limits = RST_LIMITS;
      regs.volt_beeps    = RST_VOLT_BEEPS;
      regs.signal_tones  = RST_SIGNAL_TONES;
      regs.volt_gap      = RST_GAP;
      regs.volt_pause    = RST_PAUSE;
      regs.signal_gap    = RST_GAP;
      regs.signal_pause  = RST_PAUSE;
      volt_alarm = 1'b0;
      sig_alarm  = 1'b0;
      last_tone  = '0;
      beep_cnt   = '0;
      due.delete();
      bad_count = 0;
    end else begin
      if (results.valid && results.ready) begin
        seen.tone_start       = results.tone_start;
        seen.tone_kind        = results.tone_kind;
        seen.tone_freq        = results.tone_freq;
        seen.tone_length      = results.tone_length;
        seen.volt_alarm_out   = results.volt_alarm_out;
        seen.signal_alarm_out = results.signal_alarm_out;
        seen.beep_index       = results.beep_index;
        if (due.size() == 0) begin
          bad_count++;
          if (bad_count <= 10) $display("%0t: result transaction with nothing outstanding", $time);
        end else begin
          want = due.pop_front();
          if (seen.tone_start !== want.tone_start || seen.tone_kind !== want.tone_kind ||
              seen.tone_freq !== want.tone_freq || seen.tone_length !== want.tone_length ||
              seen.volt_alarm_out !== want.volt_alarm_out ||
              seen.signal_alarm_out !== want.signal_alarm_out ||
              seen.beep_index !== want.beep_index) begin
            bad_count++;
            if (bad_count <= 10) begin
              $display("%0t: mismatch expected start=%0d kind=%0d freq=%0d len=%0d va=%0d sa=%0d idx=%0d",
                       $time, want.tone_start, want.tone_kind, want.tone_freq, want.tone_length,
                       want.volt_alarm_out, want.signal_alarm_out, want.beep_index);
              $display("%0t: mismatch actual   start=%0d kind=%0d freq=%0d len=%0d va=%0d sa=%0d idx=%0d",
                       $time, seen.tone_start, seen.tone_kind, seen.tone_freq, seen.tone_length,
                       seen.volt_alarm_out, seen.signal_alarm_out, seen.beep_index);
            end
          end
        end
      end
      if (samples.valid && samples.ready) begin
        due.push_back(beep_step(samples.now,
                                {samples.volt_3, samples.volt_2, samples.volt_1, samples.volt_0},
                                {samples.signal_3, samples.signal_2, samples.signal_1,
                                 samples.signal_0},
                                samples.volt_count, samples.signal_count));
      end
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_VOLT_LIMITS:   regs.volt_limits   = cfg.data;
          REG_SIGNAL_LIMITS: regs.signal_limits = cfg.data;
          REG_VOLT_BEEPS:    regs.volt_beeps    = cfg.data[BEEPS_W-1:0];
          REG_SIGNAL_TONES:  regs.signal_tones  = cfg.data[BEEPS_W-1:0];
          REG_VOLT_GAP:      regs.volt_gap      = cfg.data[DUR_W-1:0];
          REG_VOLT_PAUSE:    regs.volt_pause    = cfg.data[DUR_W-1:0];
          REG_SIGNAL_GAP:    regs.signal_gap    = cfg.data[DUR_W-1:0];
          REG_SIGNAL_PAUSE:  regs.signal_pause  = cfg.data[DUR_W-1:0];
          default: ;
        endcase
      end
    end
    bad_results <= bad_count;
    results_due <= due.size();
  end

endmodule

/* tb/sv/tb_low_level_alarm_beeper.sv */
// ----------------------------------------------------------------------------
// Low-level alarm beeper testbench
// Drives threshold settings and telemetry samples into the beeper: a short
// directed walk through channel masking, count saturation, tone spacing,
// rearm, priority, time wrap and single-tone sequences, then random phases
// of alarm and quiet runs under changing settings, with bursty samples and
// a stalling result sink. The monitor beside the block does the checking.
// ----------------------------------------------------------------------------
module tb_low_level_alarm_beeper;
  timeunit 1ns;
  timeprecision 1ps;
  import llab_pkg::*;

  logic clk = 1'b0;
  logic rst;
  int   bad_results;
  int   results_due;

  llab_sample_if sample_ch ();
  llab_result_if result_ch ();
  llab_cfg_if    cfg_ch ();

  low_level_alarm_beeper dut (
    .clk     (clk),
    .rst     (rst),
    .samples (sample_ch),
    .results (result_ch),
    .cfg     (cfg_ch)
  );

  llab_beep_monitor beep_watch (
    .clk         (clk),
    .rst         (rst),
    .samples     (sample_ch),
    .results     (result_ch),
    .cfg         (cfg_ch),
    .bad_results (bad_results),
    .results_due (results_due)
  );

  cfg_t       plan;
  int         burst_left = 0;
  int         sink_left  = 0;
  int         sink_mode  = 0;
  logic [7:0] sink_mask  = 8'hFF;
  logic [2:0] sink_phase = '0;

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (sink_left == 0) begin
      sink_left <= $urandom_range(60, 8);
      sink_mode <= $urandom_range(2, 0);
      sink_mask <= 8'($urandom);
    end else begin
      sink_left <= sink_left - 1;
    end
    sink_phase <= sink_phase + 3'd1;
    case (sink_mode)
      0:       result_ch.ready <= 1'b1;
      1:       result_ch.ready <= sink_mask[sink_phase];
      default: result_ch.ready <= ($urandom_range(3, 0) != 0);
    endcase
  end

  function automatic cfg_t make_plan(input logic [31:0] vl, input logic [31:0] sl,
                                     input logic [BEEPS_W-1:0] vb, input logic [BEEPS_W-1:0] sb,
                                     input logic [DUR_W-1:0] vg, input logic [DUR_W-1:0] vp,
                                     input logic [DUR_W-1:0] sg, input logic [DUR_W-1:0] sp);
    cfg_t p;
    p.volt_limits   = vl;
    p.signal_limits = sl;
    p.volt_beeps    = vb;
    p.signal_tones  = sb;
    p.volt_gap      = vg;
    p.volt_pause    = vp;
    p.signal_gap    = sg;
    p.signal_pause  = sp;
    return p;
  endfunction

  function automatic logic [31:0] random_limits();
    logic [31:0] l;
    for (int c = 0; c < MAX_CHANNELS; c++) begin
      case ($urandom_range(3, 0))
        0:       l[8*c +: 8] = DISABLED_LIMIT;
        1:       l[8*c +: 8] = 8'h00;
        default: l[8*c +: 8] = 8'($urandom);
      endcase
    end
    return l;
  endfunction

  function automatic logic [BEEPS_W-1:0] random_beeps();
    case ($urandom_range(4, 0))
      0:       return 8'd0;
      1:       return 8'd1;
      2:       return 8'd255;
      default: return 8'($urandom_range(6, 1));
    endcase
  endfunction

  function automatic logic [DUR_W-1:0] random_span();
    case ($urandom_range(5, 0))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      default: return 16'($urandom_range(500, 0));
    endcase
  endfunction

  function automatic logic [7:0] near_limit(input logic [7:0] lim);
    case ($urandom_range(3, 0))
      0:       return 8'($urandom);
      1:       return 8'hFF;
      2:       return lim - 8'd1;
      default: return lim;
    endcase
  endfunction

  function automatic logic [COUNT_W-1:0] pick_count();
    int k;
    k = $urandom_range(10, 0);
    return (k > 7) ? 3'd4 : k[COUNT_W-1:0];
  endfunction

  task automatic send_reading(input logic [31:0] t, input logic [31:0] volts,
                              input logic [31:0] sigs, input logic [COUNT_W-1:0] vc,
                              input logic [COUNT_W-1:0] sc);
    int idle;
    if (burst_left == 0) begin
      burst_left = $urandom_range(30, 1);
      idle = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(12, 1);
      if (idle > 0) begin
        sample_ch.valid <= 1'b0;
        repeat (idle) @(posedge clk);
      end
    end
    burst_left--;
    sample_ch.valid        <= 1'b1;
    sample_ch.now          <= t;
    sample_ch.volt_0       <= volts[7:0];
    sample_ch.volt_1       <= volts[15:8];
    sample_ch.volt_2       <= volts[23:16];
    sample_ch.volt_3       <= volts[31:24];
    sample_ch.signal_0     <= sigs[7:0];
    sample_ch.signal_1     <= sigs[15:8];
    sample_ch.signal_2     <= sigs[23:16];
    sample_ch.signal_3     <= sigs[31:24];
    sample_ch.volt_count   <= vc;
    sample_ch.signal_count <= sc;
    do @(posedge clk); while (!sample_ch.ready);
  endtask

  task automatic settle();
    sample_ch.valid <= 1'b0;
    do @(posedge clk); while (results_due != 0);
  endtask

  task automatic load_plan(input cfg_t p);
    cfg_reg_t    idx;
    logic [31:0] word;
    settle();
    plan = p;
    idx  = REG_VOLT_LIMITS;
    repeat (idx.num()) begin
      word = $urandom;
      case (idx)
        REG_VOLT_LIMITS:   word                = p.volt_limits;
        REG_SIGNAL_LIMITS: word                = p.signal_limits;
        REG_VOLT_BEEPS:    word[BEEPS_W-1:0]   = p.volt_beeps;
        REG_SIGNAL_TONES:  word[BEEPS_W-1:0]   = p.signal_tones;
        REG_VOLT_GAP:      word[DUR_W-1:0]     = p.volt_gap;
        REG_VOLT_PAUSE:    word[DUR_W-1:0]     = p.volt_pause;
        REG_SIGNAL_GAP:    word[DUR_W-1:0]     = p.signal_gap;
        REG_SIGNAL_PAUSE:  word[DUR_W-1:0]     = p.signal_pause;
        default: ;
      endcase
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= idx;
      cfg_ch.data  <= word;
      do @(posedge clk); while (!cfg_ch.ready);
      idx = idx.next();
    end
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic random_phase(input int items);
    logic [31:0] t;
    logic [31:0] volts;
    logic [31:0] sigs;
    logic [31:0] span;
    int          run_left;
    bit          calm;
    int          roll;
    t        = $urandom;
    run_left = 0;
    calm     = 1'b1;
    for (int n = 0; n < items; n++) begin
      if (run_left == 0) begin
        calm     = !calm;
        run_left = calm ? $urandom_range(25, 3) : $urandom_range(20, 1);
      end
      run_left--;
      span = $urandom_range(1, 0) ? 32'(plan.volt_gap) : 32'(plan.signal_gap);
      roll = $urandom_range(19, 0);
      if (roll == 0) begin
        t = $urandom;
      end else if (roll < 4) begin
        t = t + span + $urandom_range(1, 0);
      end else if (roll < 7) begin
        t = t + ($urandom_range(1, 0) ? plan.volt_pause : plan.signal_pause)
              + $urandom_range(1, 0);
      end else begin
        t = t + $urandom_range(span + span / 2 + 2, 0);
      end
      for (int c = 0; c < MAX_CHANNELS; c++) begin
        volts[8*c +: 8] = calm ? 8'hFF : near_limit(plan.volt_limits[8*c +: 8]);
        sigs[8*c +: 8]  = calm ? 8'hFF : near_limit(plan.signal_limits[8*c +: 8]);
      end
      if (roll == 19) begin
        volts = $urandom;
        sigs  = $urandom;
      end
      send_reading(t, volts, sigs, pick_count(), pick_count());
    end
  endtask

  initial begin
    sample_ch.valid        = 1'b0;
    sample_ch.now          = '0;
    sample_ch.volt_0       = '0;
    sample_ch.volt_1       = '0;
    sample_ch.volt_2       = '0;
    sample_ch.volt_3       = '0;
    sample_ch.signal_0     = '0;
    sample_ch.signal_1     = '0;
    sample_ch.signal_2     = '0;
    sample_ch.signal_3     = '0;
    sample_ch.volt_count   = '0;
    sample_ch.signal_count = '0;
    cfg_ch.valid           = 1'b0;
    cfg_ch.index           = REG_VOLT_LIMITS;
    cfg_ch.data            = '0;
    rst                    = 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    plan = make_plan(RST_LIMITS, RST_LIMITS, RST_VOLT_BEEPS, RST_SIGNAL_TONES,
                     RST_GAP, RST_PAUSE, RST_GAP, RST_PAUSE);

    // all channels disabled after reset
    send_reading(32'd50, 32'h0000_0000, 32'h0000_0000, 3'd7, 3'd7);

    load_plan(make_plan(32'h8080_80FF, 32'h0060_6060, 8'd3, 8'd2, 16'd10, 16'd40,
                        16'd10, 16'd40));
    send_reading(32'd100, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd4, 3'd4);
    send_reading(32'd101, 32'hFFFF_FF00, 32'hFFFF_FFFF, 3'd1, 3'd4);
    send_reading(32'd102, 32'hFFFF_00FF, 32'hFFFF_FFFF, 3'd1, 3'd4);
    send_reading(32'd103, 32'hFFFF_00FF, 32'hFFFF_FFFF, 3'd2, 3'd0);
    send_reading(32'd113, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd4, 3'd4);
    send_reading(32'd114, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd4, 3'd4);
    send_reading(32'd200, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd4, 3'd4);
    send_reading(32'd240, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd4, 3'd4);
    send_reading(32'd241, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd4, 3'd4);
    send_reading(32'd250, 32'hFFFF_FFFF, 32'hFF00_FFFF, 3'd0, 3'd7);
    send_reading(32'd255, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 3'd5, 3'd0);
    send_reading(32'd270, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd4, 3'd4);
    send_reading(32'd400, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 3'd4, 3'd4);
    send_reading(32'd401, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 3'd4, 3'd4);
    send_reading(32'hFFFF_FFF0, 32'hFFFF_FFFF, 32'h00FF_FFFF, 3'd4, 3'd4);
    send_reading(32'h0000_0005, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd4, 3'd4);
    send_reading(32'h0000_0030, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd4, 3'd4);

    load_plan(make_plan(32'h0000_0000, 32'hFEFE_FEFE, 8'd0, 8'd255, 16'hFFFF, 16'd0,
                        16'd0, 16'hFFFF));
    send_reading(32'd7, 32'hFFFF_FFFF, 32'h0000_0000, 3'd4, 3'd4);
    send_reading(32'd8, 32'hFFFF_FFFF, 32'h0000_0000, 3'd4, 3'd4);
    send_reading(32'd8, 32'h0000_0000, 32'hFFFF_FFFF, 3'd4, 3'd4);

    load_plan(make_plan(32'hFEFE_FEFE, 32'hFFFF_FFFF, 8'd0, 8'd1, 16'd0, 16'd0,
                        16'hFFFF, 16'hFFFF));
    send_reading(32'h9000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd4, 3'd4);
    send_reading(32'h9000_0001, 32'h0000_0000, 32'h0000_0000, 3'd4, 3'd4);
    send_reading(32'h9000_0002, 32'h0000_0000, 32'h0000_0000, 3'd4, 3'd4);
    send_reading(32'h9000_0003, 32'h0000_0000, 32'h0000_0000, 3'd4, 3'd4);

    load_plan(make_plan(32'hFEFE_FEFE, 32'h0102_FE80, 8'd255, 8'd255, 16'hFFFF, 16'hFFFF,
                        16'hFFFF, 16'hFFFF));
    random_phase(140);
    load_plan(make_plan(random_limits(), random_limits(), 8'd1, 8'd0, 16'd0, 16'd0,
                        16'd0, 16'd0));
    random_phase(140);
    repeat (4) begin
      load_plan(make_plan(random_limits(), random_limits(), random_beeps(), random_beeps(),
                          random_span(), random_span(), random_span(), random_span()));
      random_phase(140);
    end

    settle();
    repeat (4) @(posedge clk);
    if (bad_results == 0 && results_due == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
